// ===== rtl/core/casp_pkg.sv =====
// Shared types, microcode fields and register indexes of the cascaded angle/speed PID.
package casp_pkg;

  localparam int STEP_W = 5;

  // Configuration register indexes
  localparam logic [2:0] REG_ANGLE_KP   = 3'd0;
  localparam logic [2:0] REG_ANGLE_KI   = 3'd1;
  localparam logic [2:0] REG_ANGLE_KD   = 3'd2;
  localparam logic [2:0] REG_SPEED_KP   = 3'd3;
  localparam logic [2:0] REG_SPEED_KI   = 3'd4;
  localparam logic [2:0] REG_SPEED_KD   = 3'd5;
  localparam logic [2:0] REG_SPEED_ILIM = 3'd6;
  localparam logic [2:0] REG_SPEED_OLIM = 3'd7;

  typedef enum logic [3:0] {
    ALU_NOP,
    ALU_AERR,
    ALU_SUB_FT,
    ALU_ADD_FT,
    ALU_ASUM,
    ALU_ADIFF,
    ALU_CLIP,
    ALU_RND,
    ALU_SERR,
    ALU_SSUM,
    ALU_SDIFF,
    ALU_ICLIP
  } alu_op_t;

  typedef enum logic [2:0] {
    G_NONE,
    G_AKP,
    G_AKI,
    G_AKD,
    G_SKP,
    G_SKI,
    G_SKD
  } gsel_t;

  typedef enum logic [1:0] {
    B_ERR,
    B_ASUM,
    B_SSUM,
    B_DIFF
  } bsel_t;

  typedef enum logic [1:0] {
    ACC_NONE,
    ACC_LOAD,
    ACC_ADD
  } acc_op_t;

  typedef enum logic [1:0] {
    C_NEXT,
    C_ALWAYS,
    C_WRAP_LO,
    C_NOT_WRAP_HI
  } cond_t;

  typedef struct packed {
    alu_op_t           alu;
    gsel_t             gsel;
    bsel_t             bsel;
    acc_op_t           acc;
    cond_t             cond;
    logic              fin;
    logic [STEP_W-1:0] target;
  } ucw_t;

  typedef struct packed {
    logic wrap_lo;
    logic wrap_hi;
  } casp_flags_t;

  typedef struct packed {
    logic busy;
    logic done;
  } seq_stat_t;

  typedef struct packed {
    logic [15:0] angle_kp;
    logic [15:0] angle_ki;
    logic [15:0] angle_kd;
    logic [15:0] speed_kp;
    logic [15:0] speed_ki;
    logic [15:0] speed_kd;
    logic [14:0] speed_ilim;
    logic [14:0] speed_olim;
  } cfg_t;

endpackage

// ===== rtl/core/casp_useq.sv =====
// Microcode sequencer: step counter, control store and conditional jumps.
module casp_useq
  import casp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic        hold,
  input  casp_flags_t flags,
  output ucw_t        ucw,
  output seq_stat_t   stat
);

  localparam logic [STEP_W-1:0] S_ADD_FT = STEP_W'(4);
  localparam logic [STEP_W-1:0] S_ASUM   = STEP_W'(5);
  localparam logic [STEP_W-1:0] S_ZERO   = '0;

  function automatic ucw_t uw(alu_op_t a, gsel_t g, bsel_t b, acc_op_t c,
                              cond_t cd, logic f, logic [STEP_W-1:0] t);
    ucw_t w;
    w.alu    = a;
    w.gsel   = g;
    w.bsel   = b;
    w.acc    = c;
    w.cond   = cd;
    w.fin    = f;
    w.target = t;
    return w;
  endfunction

  function automatic ucw_t urom(logic [STEP_W-1:0] s);
    ucw_t w;
    case (s)
      // angle loop
      5'd0:  w = uw(ALU_AERR,   G_NONE, B_ERR,  ACC_NONE, C_NEXT,        1'b0, S_ZERO);
      5'd1:  w = uw(ALU_NOP,    G_NONE, B_ERR,  ACC_NONE, C_WRAP_LO,     1'b0, S_ADD_FT);
      5'd2:  w = uw(ALU_NOP,    G_NONE, B_ERR,  ACC_NONE, C_NOT_WRAP_HI, 1'b0, S_ASUM);
      5'd3:  w = uw(ALU_SUB_FT, G_NONE, B_ERR,  ACC_NONE, C_ALWAYS,      1'b0, S_ASUM);
      5'd4:  w = uw(ALU_ADD_FT, G_NONE, B_ERR,  ACC_NONE, C_NEXT,        1'b0, S_ZERO);
      5'd5:  w = uw(ALU_ASUM,   G_NONE, B_ERR,  ACC_NONE, C_NEXT,        1'b0, S_ZERO);
      5'd6:  w = uw(ALU_ADIFF,  G_AKP,  B_ERR,  ACC_NONE, C_NEXT,        1'b0, S_ZERO);
      5'd7:  w = uw(ALU_NOP,    G_AKI,  B_ASUM, ACC_LOAD, C_NEXT,        1'b0, S_ZERO);
      5'd8:  w = uw(ALU_NOP,    G_AKD,  B_DIFF, ACC_ADD,  C_NEXT,        1'b0, S_ZERO);
      5'd9:  w = uw(ALU_NOP,    G_NONE, B_ERR,  ACC_ADD,  C_NEXT,        1'b0, S_ZERO);
      5'd10: w = uw(ALU_CLIP,   G_NONE, B_ERR,  ACC_NONE, C_NEXT,        1'b0, S_ZERO);
      5'd11: w = uw(ALU_RND,    G_NONE, B_ERR,  ACC_NONE, C_NEXT,        1'b0, S_ZERO);
      // speed loop
      5'd12: w = uw(ALU_SERR,   G_NONE, B_ERR,  ACC_NONE, C_NEXT,        1'b0, S_ZERO);
      5'd13: w = uw(ALU_SSUM,   G_NONE, B_ERR,  ACC_NONE, C_NEXT,        1'b0, S_ZERO);
      5'd14: w = uw(ALU_SDIFF,  G_SKP,  B_ERR,  ACC_NONE, C_NEXT,        1'b0, S_ZERO);
      5'd15: w = uw(ALU_NOP,    G_SKI,  B_SSUM, ACC_LOAD, C_NEXT,        1'b0, S_ZERO);
      5'd16: w = uw(ALU_ICLIP,  G_NONE, B_ERR,  ACC_NONE, C_NEXT,        1'b0, S_ZERO);
      5'd17: w = uw(ALU_NOP,    G_SKD,  B_DIFF, ACC_ADD,  C_NEXT,        1'b0, S_ZERO);
      5'd18: w = uw(ALU_NOP,    G_NONE, B_ERR,  ACC_ADD,  C_NEXT,        1'b0, S_ZERO);
      5'd19: w = uw(ALU_CLIP,   G_NONE, B_ERR,  ACC_NONE, C_NEXT,        1'b0, S_ZERO);
      5'd20: w = uw(ALU_RND,    G_NONE, B_ERR,  ACC_NONE, C_NEXT,        1'b0, S_ZERO);
      5'd21: w = uw(ALU_NOP,    G_NONE, B_ERR,  ACC_NONE, C_NEXT,        1'b1, S_ZERO);
      default: w = uw(ALU_NOP,  G_NONE, B_ERR,  ACC_NONE, C_NEXT,        1'b1, S_ZERO);
    endcase
    return w;
  endfunction

  logic              busy_r;
  logic [STEP_W-1:0] step_r;
  logic              jump;

  always_comb begin
    if (busy_r) begin
      ucw = urom(step_r);
    end else begin
      ucw = uw(ALU_NOP, G_NONE, B_ERR, ACC_NONE, C_NEXT, 1'b0, S_ZERO);
    end
    case (ucw.cond)
      C_ALWAYS:      jump = 1'b1;
      C_WRAP_LO:     jump = flags.wrap_lo;
      C_NOT_WRAP_HI: jump = !flags.wrap_hi;
      default:       jump = 1'b0;
    endcase
    stat.busy = busy_r;
    stat.done = busy_r && ucw.fin && !hold;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (!busy_r) begin
      if (start) begin
        busy_r <= 1'b1;
        step_r <= '0;
      end
    end else if (ucw.fin) begin
      if (!hold) begin
        busy_r <= 1'b0;
        step_r <= '0;
      end
    end else if (jump) begin
      step_r <= ucw.target;
    end else begin
      step_r <= step_r + STEP_W'(1);
    end
  end

endmodule

// ===== rtl/core/casp_dpath.sv =====
// Datapath: shared multiplier, accumulator, clamps, rounding and loop state.
module casp_dpath
  import casp_pkg::*;
#(
  parameter int FULL_TURN            = 8192,
  parameter int ANGLE_INTEGRAL_LIMIT = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  input  ucw_t               ucw,
  input  cfg_t               cfg,
  input  logic signed [15:0] tgt,
  input  logic signed [15:0] meas,
  input  logic signed [15:0] spd,
  output casp_flags_t        flags,
  output logic signed [15:0] res
);

  localparam logic signed [17:0] FT18  = 18'(FULL_TURN);
  localparam logic signed [19:0] FT20  = 20'(FULL_TURN);
  localparam logic signed [32:0] AIL33 = 33'(ANGLE_INTEGRAL_LIMIT);

  // loop state
  logic signed [17:0] a_last_r, a_last_nxt;
  logic signed [31:0] a_sum_r,  a_sum_nxt;
  logic signed [17:0] s_last_r, s_last_nxt;
  logic signed [31:0] s_sum_r,  s_sum_nxt;
  // working registers
  logic signed [17:0] err_r,  err_nxt;
  logic signed [18:0] diff_r, diff_nxt;
  logic signed [48:0] prod_r, prod_nxt;
  logic signed [49:0] acc_r,  acc_nxt;
  logic signed [15:0] res_r,  res_nxt;

  logic        [15:0] gain;
  logic signed [31:0] mb;
  logic signed [48:0] mul;
  logic signed [19:0] err2;
  logic signed [32:0] asum33, ssum33;
  logic        [14:0] ilim;
  logic signed [48:0] ilim49;
  logic signed [49:0] olim50, rnd50;

  always_comb begin
    case (ucw.gsel)
      G_AKP:   gain = cfg.angle_kp;
      G_AKI:   gain = cfg.angle_ki;
      G_AKD:   gain = cfg.angle_kd;
      G_SKP:   gain = cfg.speed_kp;
      G_SKI:   gain = cfg.speed_ki;
      G_SKD:   gain = cfg.speed_kd;
      default: gain = '0;
    endcase
    case (ucw.bsel)
      B_ASUM:  mb = a_sum_r;
      B_SSUM:  mb = s_sum_r;
      B_DIFF:  mb = {{13{diff_r[18]}}, diff_r};
      default: mb = {{14{err_r[17]}}, err_r};
    endcase
    mul = $signed({1'b0, gain}) * mb;

    err2          = {err_r[17], err_r, 1'b0};
    flags.wrap_lo = err2 < -FT20;
    flags.wrap_hi = err2 > FT20;

    asum33 = {a_sum_r[31], a_sum_r} + {{15{err_r[17]}}, err_r};
    ssum33 = {s_sum_r[31], s_sum_r} + {{15{err_r[17]}}, err_r};
    ilim   = (cfg.speed_ilim > cfg.speed_olim) ? cfg.speed_olim : cfg.speed_ilim;
    ilim49 = $signed({26'd0, ilim, 8'd0});
    olim50 = $signed({27'd0, cfg.speed_olim, 8'd0});
    rnd50  = acc_r + 50'sd128;

    a_last_nxt = a_last_r;
    a_sum_nxt  = a_sum_r;
    s_last_nxt = s_last_r;
    s_sum_nxt  = s_sum_r;
    err_nxt    = err_r;
    diff_nxt   = diff_r;
    prod_nxt   = (ucw.gsel != G_NONE) ? mul : prod_r;
    res_nxt    = res_r;

    case (ucw.acc)
      ACC_LOAD: acc_nxt = {prod_r[48], prod_r};
      ACC_ADD:  acc_nxt = acc_r + {prod_r[48], prod_r};
      default:  acc_nxt = acc_r;
    endcase

    case (ucw.alu)
      ALU_AERR:   err_nxt = {{2{tgt[15]}}, tgt} - {{2{meas[15]}}, meas};
      ALU_SUB_FT: err_nxt = err_r - FT18;
      ALU_ADD_FT: err_nxt = err_r + FT18;
      ALU_ASUM: begin
        if (asum33 > AIL33) begin
          a_sum_nxt = AIL33[31:0];
        end else if (asum33 < -AIL33) begin
          a_sum_nxt = 32'(-AIL33);
        end else begin
          a_sum_nxt = asum33[31:0];
        end
      end
      ALU_ADIFF: begin
        diff_nxt   = {err_r[17], err_r} - {a_last_r[17], a_last_r};
        a_last_nxt = err_r;
      end
      ALU_CLIP: begin
        if (acc_r > olim50) begin
          acc_nxt = olim50;
        end else if (acc_r < -olim50) begin
          acc_nxt = -olim50;
        end
      end
      ALU_RND:  res_nxt = rnd50[23:8];
      ALU_SERR: err_nxt = {{2{res_r[15]}}, res_r} - {{2{spd[15]}}, spd};
      ALU_SSUM: begin
        if (ssum33[32] != ssum33[31]) begin
          s_sum_nxt = ssum33[32] ? 32'h8000_0000 : 32'h7fff_ffff;
        end else begin
          s_sum_nxt = ssum33[31:0];
        end
      end
      ALU_SDIFF: begin
        diff_nxt   = {err_r[17], err_r} - {s_last_r[17], s_last_r};
        s_last_nxt = err_r;
      end
      ALU_ICLIP: begin
        if (prod_r > ilim49) begin
          prod_nxt = ilim49;
        end else if (prod_r < -ilim49) begin
          prod_nxt = -ilim49;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_last_r <= '0;
      a_sum_r  <= '0;
      s_last_r <= '0;
      s_sum_r  <= '0;
    end else begin
      a_last_r <= a_last_nxt;
      a_sum_r  <= a_sum_nxt;
      s_last_r <= s_last_nxt;
      s_sum_r  <= s_sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r  <= err_nxt;
    diff_r <= diff_nxt;
    prod_r <= prod_nxt;
    acc_r  <= acc_nxt;
    res_r  <= res_nxt;
  end

  assign res = res_r;

endmodule

// ===== rtl/core/cascade_angle_speed_pid_top.sv =====
// Top level of the cascaded angle/speed PID controller.
//
//  channel  direction  handshake          payload
//  in_      in         in_valid/in_stall  desired_angle, measured_angle, measured_speed
//  out_     out        out_valid/out_stall drive
//  cfg_     in         cfg_valid/cfg_ready cfg_index (3b), cfg_data (16b)
//
// A tick runs as a microprogram of 20 or 21 steps (21 when the angle error is
// wrapped down by one turn) on one shared 17x32 multiplier; the block takes
// one item at a time, and the next item is taken the cycle after the last step.
// A result waiting in the output register does not block a new transaction;
// the sequencer holds on its last step only while the previous one is stalled.
// rst_n is synchronous: gains, limits and loop state clear to zero.
module cascade_angle_speed_pid_top
  import casp_pkg::*;
#(
  parameter int FULL_TURN            = 8192,
  parameter int ANGLE_INTEGRAL_LIMIT = 65535
) (
  input  logic               clk,
  input  logic               rst_n,
  // input transactions
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [15:0] in_desired_angle,
  input  logic signed [15:0] in_measured_angle,
  input  logic signed [15:0] in_measured_speed,
  // result transactions
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [15:0] out_drive,
  // register writes
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [2:0]         cfg_index,
  input  logic [15:0]        cfg_data
);

  cfg_t               cfg_r;
  logic signed [15:0] tgt_r, meas_r, spd_r;
  logic               out_valid_r;
  logic signed [15:0] out_drive_r;

  ucw_t               ucw;
  seq_stat_t          stat;
  casp_flags_t        flags;
  logic signed [15:0] res;
  logic               in_take;
  logic               out_hold;

  assign in_stall  = stat.busy;
  assign in_take   = in_valid && !stat.busy;
  assign out_hold  = out_valid_r && out_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_drive = out_drive_r;

  // register file; the user must have writes arrive only while idle; the block does not enforce it
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_ANGLE_KP:   cfg_r.angle_kp   <= cfg_data;
        REG_ANGLE_KI:   cfg_r.angle_ki   <= cfg_data;
        REG_ANGLE_KD:   cfg_r.angle_kd   <= cfg_data;
        REG_SPEED_KP:   cfg_r.speed_kp   <= cfg_data;
        REG_SPEED_KI:   cfg_r.speed_ki   <= cfg_data;
        REG_SPEED_KD:   cfg_r.speed_kd   <= cfg_data;
        REG_SPEED_ILIM: cfg_r.speed_ilim <= cfg_data[14:0];
        REG_SPEED_OLIM: cfg_r.speed_olim <= cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // input payload capture
  always_ff @(posedge clk) begin
    if (in_take) begin
      tgt_r  <= in_desired_angle;
      meas_r <= in_measured_angle;
      spd_r  <= in_measured_speed;
    end
  end

  // output register: loaded on the final step, freed when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stat.done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.done) begin
      out_drive_r <= res;
    end
  end

  casp_useq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .start (in_take),
    .hold  (out_hold),
    .flags (flags),
    .ucw   (ucw),
    .stat  (stat)
  );

  casp_dpath #(
    .FULL_TURN            (FULL_TURN),
    .ANGLE_INTEGRAL_LIMIT (ANGLE_INTEGRAL_LIMIT)
  ) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .ucw   (ucw),
    .cfg   (cfg_r),
    .tgt   (tgt_r),
    .meas  (meas_r),
    .spd   (spd_r),
    .flags (flags),
    .res   (res)
  );

endmodule

// ===== bench/tb.sv =====
// Testbench for the cascaded angle/speed PID: directed and random ticks checked against a predictor.
`timescale 1ns / 100ps

module tb;
  import casp_pkg::*;

  // Loop constants, passed to the block so both sides agree
  localparam int TURN_COUNTS     = 8192;
  localparam int ANGLE_SUM_LIMIT = 65535;

  localparam longint INT32_HI = 64'sd2147483647;
  localparam longint INT32_LO = -64'sd2147483648;

  // Settling pause after a drain, longer than a tick through the microprogram
  localparam int SETTLE_CYCLES = 30;
  // Long receiver hold-off, enough to fill the block and push back on the input
  localparam int HOLD_CYCLES   = 200;
  // Ticks at the largest speed error, driving the speed error sum up fast
  localparam int SWING_TICKS   = 40;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_stall;
  logic signed [15:0] in_desired_angle;
  logic signed [15:0] in_measured_angle;
  logic signed [15:0] in_measured_speed;
  logic               out_valid;
  logic               out_stall;
  logic signed [15:0] out_drive;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [2:0]         cfg_index;
  logic [15:0]        cfg_data;

  cascade_angle_speed_pid_top #(
    .FULL_TURN            (TURN_COUNTS),
    .ANGLE_INTEGRAL_LIMIT (ANGLE_SUM_LIMIT)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_desired_angle  (in_desired_angle),
    .in_measured_angle (in_measured_angle),
    .in_measured_speed (in_measured_speed),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_drive         (out_drive),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // Predictor: register copy, loop state, and the expected drive queue
  // ---------------------------------------------------------------------------
  longint ang_kp = 0, ang_ki = 0, ang_kd = 0;
  longint spd_kp = 0, spd_ki = 0, spd_kd = 0;
  longint spd_ilim = 0, spd_olim = 0;

  longint ang_err_prev = 0, ang_err_total = 0;
  longint spd_err_prev = 0, spd_err_total = 0;

  logic signed [15:0] expected_drive[$];

  int  errors = 0;
  bit  gaps_on = 1'b0;       // sender inserts random gaps between transactions
  bit  stalls_on = 1'b0;     // receiver stalls at random
  int  hold_requests = 0;    // bumped to ask the receiver for one long hold-off

  function automatic longint clip(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // Q8 value to integer, halves toward plus infinity
  function automatic longint round_half_up(input longint v);
    return (v + 128) >>> 8;
  endfunction

  // Mirror a register write; the limit registers keep only 15 bits
  function automatic void apply_reg(input logic [2:0] idx, input logic [15:0] data);
    case (idx)
      REG_ANGLE_KP:   ang_kp   = longint'(data);
      REG_ANGLE_KI:   ang_ki   = longint'(data);
      REG_ANGLE_KD:   ang_kd   = longint'(data);
      REG_SPEED_KP:   spd_kp   = longint'(data);
      REG_SPEED_KI:   spd_ki   = longint'(data);
      REG_SPEED_KD:   spd_kd   = longint'(data);
      REG_SPEED_ILIM: spd_ilim = longint'(data[14:0]);
      REG_SPEED_OLIM: spd_olim = longint'(data[14:0]);
      default: ;
    endcase
  endfunction

  // One control tick: angle loop gives the speed setpoint, speed loop gives the drive
  function automatic logic signed [15:0] predict_drive(input logic signed [15:0] tgt,
                                                       input logic signed [15:0] meas,
                                                       input logic signed [15:0] spd);
    longint ilim, err, total, acc, setpoint, iterm, drv;
    ilim = (spd_ilim > spd_olim) ? spd_olim : spd_ilim;

    // angle loop, error wrapped by one turn at most
    err = longint'(tgt) - longint'(meas);
    if (2 * err > TURN_COUNTS) err -= TURN_COUNTS;
    else if (2 * err < -TURN_COUNTS) err += TURN_COUNTS;
    total = clip(ang_err_total + err, ANGLE_SUM_LIMIT);
    acc = ang_kp * err + ang_ki * total + ang_kd * (err - ang_err_prev);
    setpoint = round_half_up(clip(acc, spd_olim * 256));
    ang_err_total = total;
    ang_err_prev  = err;

    // speed loop, error sum saturates at the 32-bit range
    err = setpoint - longint'(spd);
    total = spd_err_total + err;
    if (total > INT32_HI) total = INT32_HI;
    else if (total < INT32_LO) total = INT32_LO;
    iterm = clip(spd_ki * total, ilim * 256);
    acc = spd_kp * err + iterm + spd_kd * (err - spd_err_prev);
    drv = round_half_up(clip(acc, spd_olim * 256));
    spd_err_total = total;
    spd_err_prev  = err;
    return drv[15:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Clock, timeout
  // ---------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off counted here on request
  // ---------------------------------------------------------------------------
  initial begin
    int run_left;
    int hold_left;
    int hold_seen;
    int r;
    bit level;
    out_stall = 1'b0;
    run_left  = 0;
    hold_left = 0;
    hold_seen = 0;
    level     = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall = 1'b1;
      end else if (!stalls_on) begin
        out_stall = 1'b0;
      end else begin
        if (run_left == 0) begin
          r = $urandom_range(0, 99);
          // mostly short runs, now and then a long stall
          if (r < 65) begin
            level = 1'b0;
            run_left = $urandom_range(1, 6);
          end else if (r < 95) begin
            level = 1'b1;
            run_left = $urandom_range(1, 4);
          end else begin
            level = 1'b1;
            run_left = $urandom_range(15, 50);
          end
        end
        run_left--;
        out_stall = level;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result checker: every accepted result against the oldest expectation
  // ---------------------------------------------------------------------------
  logic signed [15:0] want;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_drive.size() == 0) begin
        errors++;
        $display("%0t: unexpected drive transaction, actual %0d", $time, out_drive);
      end else begin
        want = expected_drive.pop_front();
        if (out_drive !== want) begin
          errors++;
          $display("%0t: drive mismatch, expected %0d actual %0d", $time, want, out_drive);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sender side helpers
  // ---------------------------------------------------------------------------
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // One input transaction; the expectation is queued when it is taken
  task automatic send_tick(input logic signed [15:0] tgt,
                           input logic signed [15:0] meas,
                           input logic signed [15:0] spd);
    int gap;
    gap = gaps_on ? pick_gap() : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 1'b0;
      in_desired_angle  = 16'($urandom);   // junk while idle
      in_measured_angle = 16'($urandom);
      in_measured_speed = 16'($urandom);
      repeat (gap) @(negedge clk);
    end
    in_valid          = 1'b1;
    in_desired_angle  = tgt;
    in_measured_angle = meas;
    in_measured_speed = spd;
    do @(posedge clk); while (in_stall);
    expected_drive.push_back(predict_drive(tgt, meas, spd));
  endtask

  // Stop sending, wait for every expected result, then let the block settle
  task automatic wait_drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_drive.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // All eight registers, written only once the block is idle
  task automatic configure(input logic [15:0] akp, input logic [15:0] aki,
                           input logic [15:0] akd, input logic [15:0] skp,
                           input logic [15:0] ski, input logic [15:0] skd,
                           input logic [15:0] ilim, input logic [15:0] olim);
    wait_drain();
    write_reg(REG_ANGLE_KP, akp);
    write_reg(REG_ANGLE_KI, aki);
    write_reg(REG_ANGLE_KD, akd);
    write_reg(REG_SPEED_KP, skp);
    write_reg(REG_SPEED_KI, ski);
    write_reg(REG_SPEED_KD, skd);
    write_reg(REG_SPEED_ILIM, ilim);
    write_reg(REG_SPEED_OLIM, olim);
  endtask

  function automatic logic signed [15:0] extreme_value();
    case ($urandom_range(0, 5))
      0:       return 16'sh8000;
      1:       return 16'sh8001;
      2:       return 16'shFFFF;
      3:       return 16'sh0000;
      4:       return 16'sh0001;
      default: return 16'sh7FFF;
    endcase
  endfunction

  // Random tick: mostly tracking-style angles, some near the half-turn wrap,
  // some extremes and plain noise
  task automatic random_tick();
    logic signed [15:0] tgt, meas, spd;
    int mode;
    tgt  = ($urandom_range(0, 99) < 15) ? extreme_value() : 16'($urandom);
    mode = $urandom_range(0, 99);
    if (mode < 50)
      meas = 16'(tgt + $urandom_range(0, 400) - 200);
    else if (mode < 65)
      meas = $urandom_range(0, 1) ? 16'(tgt - 4093 - $urandom_range(0, 6))
                                  : 16'(tgt + 4093 + $urandom_range(0, 6));
    else if (mode < 80)
      meas = extreme_value();
    else
      meas = 16'($urandom);
    mode = $urandom_range(0, 99);
    if (mode < 60)
      spd = 16'($urandom_range(0, 600) - 300);
    else if (mode < 85)
      spd = 16'($urandom);
    else
      spd = extreme_value();
    send_tick(tgt, meas, spd);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset leaves all gains and limits at zero, so the drive is zero;
  // a zero output limit keeps it zero whatever the gains
  task automatic test_zero_output_limit();
    send_tick(16'sh7FFF, 16'sh8000, 16'sh8000);
    send_tick(16'sh8000, 16'sh7FFF, 16'sh7FFF);
    send_tick(16'sh0000, 16'sh0000, 16'sh0000);
    configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'h0000);
    send_tick(16'sd3000, -16'sd3000, 16'sh8000);
    send_tick(-16'sd100, 16'sd100, 16'sh7FFF);
  endtask

  // Half-turn test at and just past the boundary, in both directions,
  // and the widest error (one wrap only), then the extreme speeds
  task automatic test_half_turn_wrap();
    configure(16'h0100, 16'h0000, 16'h0040, 16'h0100, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF);
    send_tick(16'sd4096, 16'sd0, 16'sd0);
    send_tick(16'sd4097, 16'sd0, 16'sd0);
    send_tick(-16'sd4096, 16'sd0, 16'sd0);
    send_tick(-16'sd4097, 16'sd0, 16'sd0);
    send_tick(16'sh7FFF, 16'sh8000, 16'sd0);
    send_tick(16'sh8000, 16'sh7FFF, 16'sd0);
    send_tick(16'sd0, 16'sd0, 16'sh7FFF);
    send_tick(16'sd0, 16'sd0, 16'sh8000);
    send_tick(16'sd0, 16'sd0, 16'sd0);
    send_tick(16'sd0, 16'sd0, 16'sd0);
  endtask

  // Half gain on odd errors lands exactly on .5: rounds toward plus infinity
  task automatic test_rounding();
    configure(16'h0080, 16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h7FFF, 16'h7FFF);
    send_tick(16'sd1, 16'sd0, 16'sd0);
    send_tick(-16'sd1, 16'sd0, 16'sd0);
    send_tick(16'sd3, 16'sd0, 16'sd0);
    send_tick(-16'sd3, 16'sd0, 16'sd0);
  endtask

  // Integral limit above, then below, the output limit: the smaller one clamps ki*sum
  task automatic test_integral_clamp();
    configure(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'h7FFF, 16'd1000);
    repeat (3) send_tick(16'sd500, 16'sd0, 16'sd0);
    configure(16'h0100, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 16'd200, 16'd30000);
    repeat (3) send_tick(16'sd500, 16'sd0, -16'sd500);
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // then the sender waits until every result is back
  task automatic test_backpressure();
    configure(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 255)),
              16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
              16'($urandom_range(0, 255)), 16'($urandom_range(0, 1023)),
              16'd20000, 16'd30000);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    hold_requests++;
    repeat (12) random_tick();
    wait_drain();
  endtask

  // Push the speed error sum hard with the largest error per tick,
  // then pull it back with the opposite error
  task automatic test_speed_sum_swing();
    configure(16'hFFFF, 16'h0000, 16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'h7FFF, 16'h7FFF);
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    repeat (SWING_TICKS) send_tick(16'sd4000, 16'sd0, 16'(32768 + $urandom_range(0, 15)));
    repeat (40) send_tick(-16'sd4000, 16'sd0, 16'(32767 - $urandom_range(0, 15)));
    wait_drain();
  endtask

  // Random ticks over a series of register settings, extremes included
  task automatic test_random_traffic();
    int olim;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        // everything at maximum; limit writes carry bit 15 too
        0: configure(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                     16'hFFFF, 16'hFFFF);
        1: configure(16'($urandom_range(0, 768)), 16'($urandom_range(0, 64)),
                     16'($urandom_range(0, 768)), 16'($urandom_range(0, 768)),
                     16'($urandom_range(0, 64)), 16'($urandom_range(0, 768)),
                     16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
        2: begin
          olim = $urandom_range(0, 2000);
          configure(16'($urandom_range(0, 1023)), 16'($urandom_range(0, 128)),
                    16'($urandom_range(0, 1023)), 16'($urandom_range(0, 1023)),
                    16'($urandom_range(0, 4096)), 16'($urandom_range(0, 1023)),
                    16'($urandom_range(olim + 1, 32767)), 16'(olim));
        end
        3: configure(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        4: configure(16'($urandom_range(0, 512)), 16'($urandom_range(0, 64)),
                     16'($urandom_range(0, 512)), 16'($urandom_range(0, 512)),
                     16'($urandom_range(0, 64)), 16'($urandom_range(0, 512)),
                     16'd1, 16'd1);
        default: configure(16'($urandom_range(0, 300)), 16'($urandom_range(0, 16)),
                           16'($urandom_range(0, 300)), 16'($urandom_range(0, 300)),
                           16'($urandom_range(0, 16)), 16'($urandom_range(0, 300)),
                           16'h7FFF, 16'h7FFF);
      endcase
      // one phase runs back to back with no idling at all
      gaps_on   = (ph != 2);
      stalls_on = (ph != 2);
      repeat (200) random_tick();
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    in_valid          = 1'b0;
    in_desired_angle  = '0;
    in_measured_angle = '0;
    in_measured_speed = '0;
    cfg_valid         = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_zero_output_limit();
    test_half_turn_wrap();
    test_rounding();
    test_integral_clamp();
    test_backpressure();
    test_speed_sum_swing();
    test_random_traffic();

    wait_drain();
    if (errors == 0 && expected_drive.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
